>>> rtl/tpm_pkg.sv
// shared constants and types for the tile pair move-to-front encoder
package tpm_pkg;

  // widths fixed by the code format
  localparam int INDEX_W   = 11;
  localparam int POS_W     = 4;
  localparam int COUNT_W   = 5;
  localparam int CODE_W    = 12;
  localparam int BITS_W    = 25;
  localparam int LEN_W     = 5;
  localparam int HISTORY_DEPTH_DEFAULT = 16;

  // code lengths of a hit field and a miss field
  localparam logic [LEN_W-1:0] LEN_HIT  = 5'd5;
  localparam logic [LEN_W-1:0] LEN_MISS = 5'd12;

  // update command broadcast to every history cell
  typedef struct packed {
    logic             en;     // shift this cycle
    logic [POS_W-1:0] limit;  // cells at or below this position shift
  } cell_ctrl_t;

endpackage

>>> rtl/tpm_cell.sv
// one history entry of the move-to-front chain
module tpm_cell
  import tpm_pkg::*;
#(
  parameter int POS = 0
) (
  input  logic               clk,
  input  logic [INDEX_W-1:0] key,
  input  logic [INDEX_W-1:0] nb_entry,  // entry of the cell in front, key for the front cell
  input  logic [COUNT_W-1:0] count,
  input  cell_ctrl_t         ctrl,
  output logic [INDEX_W-1:0] entry,
  output logic               match
);

  localparam logic [POS_W-1:0]   MY_POS   = POS_W'(POS);
  localparam logic [COUNT_W-1:0] MY_COUNT = COUNT_W'(POS);

  // compare only entries that have been written
  assign match = (entry == key) && (MY_COUNT < count);

  // take the neighbor's entry when the shift reaches this cell
  always_ff @(posedge clk) begin
    if (ctrl.en && (MY_POS <= ctrl.limit)) begin
      entry <= nb_entry;
    end
  end

endmodule

>>> rtl/tile_pair_mtf_encoder.sv
// Tile pair move-to-front encoder. Each input beat carries two 11-bit tile
// indices and the flip flag of the first tile; each output beat carries one
// code word, right-aligned with the earliest bit highest, and its length
// (6 to 25 bits). The first index is coded against a history of the most
// recent indices (hit: 1 + 4-bit position, miss: 0 + 11-bit index); then a
// single 1 marks a successor second index, or a 0 is followed by the second
// index coded the same way. The history is a chain of cells that all compare
// against the key at once and shift toward the back in the same cycle. A pair
// with a successor second index needs only the first lookup, else a second
// lookup follows; finishing waits while the output register is full, and the
// next beat is taken in the cycle the current code word is written to the
// output register. The history needs no clearing after reset.
module tile_pair_mtf_encoder
  import tpm_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // first_index[10:0], second_index[21:11], zero pad
  input  logic [0:0]  s_tuser,   // first_hflip
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // code_bits[24:0], code_length[29:25], zero pad
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FIRST  = 2'd1;
  localparam logic [1:0] ST_SECOND = 2'd2;

  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(HISTORY_DEPTH);
  localparam logic [POS_W-1:0]   LAST_P  = POS_W'(HISTORY_DEPTH - 1);

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [COUNT_W-1:0] count;
  logic [INDEX_W-1:0] first_q;
  logic [INDEX_W-1:0] second_q;
  logic               flip_q;
  logic [CODE_W-1:0]  part_code;
  logic               part_hit;

  logic [INDEX_W-1:0] key;
  logic [HISTORY_DEPTH-1:0] match;
  logic [INDEX_W-1:0] entries [HISTORY_DEPTH];
  logic               hit;
  logic [POS_W-1:0]   pos;
  logic [CODE_W-1:0]  cur_code;
  logic               succ;
  logic               out_busy;
  logic               step;
  logic               done;
  cell_ctrl_t         ctrl;
  logic [BITS_W-1:0]  res_bits;
  logic [LEN_W-1:0]   res_len;

  // key for this cycle's lookup
  assign key = (state == ST_SECOND) ? second_q : first_q;

  // history chain, front cell fed by the key
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    logic [INDEX_W-1:0] nb;
    if (i == 0) begin : g_front
      assign nb = key;
    end else begin : g_rest
      assign nb = entries[i-1];
    end
    tpm_cell #(.POS(i)) u_cell (
      .clk      (clk),
      .key      (key),
      .nb_entry (nb),
      .count    (count),
      .ctrl     (ctrl),
      .entry    (entries[i]),
      .match    (match[i])
    );
  end

  // lowest matching position
  always_comb begin
    pos = '0;
    for (int i = HISTORY_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = POS_W'(i);
      end
    end
  end
  assign hit = |match;

  // field code for the current key
  assign cur_code = hit ? {7'd0, 1'b1, pos} : {1'b0, key};

  // successor test without wrap
  always_comb begin
    if (flip_q) begin
      succ = (first_q != '0) && (second_q == first_q - 1'b1);
    end else begin
      succ = (first_q != '1) && (second_q == first_q + 1'b1);
    end
  end

  // step control: finishing needs a free output register
  assign out_busy = m_tvalid && !m_tready;
  always_comb begin
    step = 1'b0;
    done = 1'b0;
    case (state)
      ST_FIRST: begin
        step = !(succ && out_busy);
        done = succ && !out_busy;
      end
      ST_SECOND: begin
        step = !out_busy;
        done = !out_busy;
      end
      default: begin
        step = 1'b0;
        done = 1'b0;
      end
    endcase
  end

  // shift command for the chain
  always_comb begin
    ctrl.en = step;
    if (hit) begin
      ctrl.limit = pos;
    end else if (count == DEPTH_C) begin
      ctrl.limit = LAST_P;
    end else begin
      ctrl.limit = count[POS_W-1:0];
    end
  end

  assign s_tready = (state == ST_IDLE) || done;

  // code word assembly
  always_comb begin
    if (state == ST_FIRST) begin
      if (hit) begin
        res_bits = BITS_W'({cur_code[POS_W:0], 1'b1});
        res_len  = LEN_HIT + 5'd1;
      end else begin
        res_bits = BITS_W'({cur_code, 1'b1});
        res_len  = LEN_MISS + 5'd1;
      end
    end else begin
      if (hit) begin
        res_bits = BITS_W'({part_code, 1'b0, cur_code[POS_W:0]});
        res_len  = (part_hit ? LEN_HIT : LEN_MISS) + 5'd1 + LEN_HIT;
      end else begin
        res_bits = BITS_W'({part_code, 1'b0, cur_code});
        res_len  = (part_hit ? LEN_HIT : LEN_MISS) + 5'd1 + LEN_MISS;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_FIRST;
      end
      ST_FIRST: begin
        if (done) begin
          state_next = s_tvalid ? ST_FIRST : ST_IDLE;
        end else if (step) begin
          state_next = ST_SECOND;
        end
      end
      ST_SECOND: begin
        if (done) state_next = s_tvalid ? ST_FIRST : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (step && !hit && (count != DEPTH_C)) begin
        count <= count + 1'b1;
      end
      if (done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      first_q  <= s_tdata[10:0];
      second_q <= s_tdata[21:11];
      flip_q   <= s_tuser[0];
    end
    if ((state == ST_FIRST) && step) begin
      part_code <= cur_code;
      part_hit  <= hit;
    end
    if (done) begin
      m_tdata <= {2'b00, res_len, res_bits};
    end
  end

  // at most one live entry matches, since a hit never inserts
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> $onehot0(match))
    else $error("duplicate history entries");

  // fill count stays within the history
  assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("history count overflow");

  // a new output beat only comes out of a lookup state
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_FIRST || $past(state) == ST_SECOND))
    else $error("output beat without lookup");

  // an accepted beat starts with the first lookup
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_FIRST))
    else $error("accepted beat not started");

  // code length is one of the legal totals
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[29:25] == 5'd6 || m_tdata[29:25] == 5'd13 ||
                  m_tdata[29:25] == 5'd11 || m_tdata[29:25] == 5'd18 ||
                  m_tdata[29:25] == 5'd25))
    else $error("illegal code length");

endmodule
